/* rtl/chip8_instruction_core_defines.svh */
// ============================================================================
// chip8_instruction_core_defines.svh
// Assertion macros shared by the CHIP-8 core.
// ============================================================================
`ifndef CHIP8_INSTRUCTION_CORE_DEFINES_SVH
`define CHIP8_INSTRUCTION_CORE_DEFINES_SVH

// same-cycle implication
`define C8_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("c8core check failed");

// next-cycle implication
`define C8_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("c8core check failed");

`endif

/* rtl/c8core_pkg.sv */
// ============================================================================
// c8core_pkg
// Types, opcode codes and the font table of the CHIP-8 core.
// ============================================================================
package c8core_pkg;

	localparam int DEF_MEM_BYTES     = 4096;
	localparam int DEF_STACK_DEPTH   = 16;
	localparam int DEF_SCREEN_WIDTH  = 64;
	localparam int DEF_SCREEN_HEIGHT = 32;

	localparam int ALU_W      = 13;
	localparam int NUM_REGS   = 16;
	localparam int FONT_BYTES = 80;
	localparam int PADDR_W    = 3;

	localparam logic [11:0] PC_RESET     = 12'h200;
	localparam logic        REG_ORIGINAL = 1'b0;

	typedef enum logic [1:0] {
		KIND_EXEC = 2'd0,
		KIND_TICK = 2'd1,
		KIND_LOAD = 2'd2,
		KIND_ROW  = 2'd3
	} kind_t;

	localparam logic [3:0] GRP_SYS  = 4'h0;
	localparam logic [3:0] GRP_JP   = 4'h1;
	localparam logic [3:0] GRP_CALL = 4'h2;
	localparam logic [3:0] GRP_SEI  = 4'h3;
	localparam logic [3:0] GRP_SNEI = 4'h4;
	localparam logic [3:0] GRP_SER  = 4'h5;
	localparam logic [3:0] GRP_LDI  = 4'h6;
	localparam logic [3:0] GRP_ADDI = 4'h7;
	localparam logic [3:0] GRP_ARI  = 4'h8;
	localparam logic [3:0] GRP_SNER = 4'h9;
	localparam logic [3:0] GRP_LDIX = 4'hA;
	localparam logic [3:0] GRP_JPO  = 4'hB;
	localparam logic [3:0] GRP_RND  = 4'hC;
	localparam logic [3:0] GRP_DRW  = 4'hD;
	localparam logic [3:0] GRP_KEY  = 4'hE;
	localparam logic [3:0] GRP_MISC = 4'hF;

	localparam logic [3:0] AR_MOV  = 4'h0;
	localparam logic [3:0] AR_OR   = 4'h1;
	localparam logic [3:0] AR_AND  = 4'h2;
	localparam logic [3:0] AR_XOR  = 4'h3;
	localparam logic [3:0] AR_ADD  = 4'h4;
	localparam logic [3:0] AR_SUB  = 4'h5;
	localparam logic [3:0] AR_SHR  = 4'h6;
	localparam logic [3:0] AR_SUBN = 4'h7;
	localparam logic [3:0] AR_SHL  = 4'hE;

	localparam logic [7:0] NN_CLS  = 8'hE0;
	localparam logic [7:0] NN_RET  = 8'hEE;
	localparam logic [7:0] NN_SKP  = 8'h9E;
	localparam logic [7:0] NN_SKNP = 8'hA1;
	localparam logic [7:0] NN_LDDT = 8'h07;
	localparam logic [7:0] NN_WKEY = 8'h0A;
	localparam logic [7:0] NN_SDT  = 8'h15;
	localparam logic [7:0] NN_SST  = 8'h18;
	localparam logic [7:0] NN_ADDX = 8'h1E;
	localparam logic [7:0] NN_FONT = 8'h29;
	localparam logic [7:0] NN_BCD  = 8'h33;
	localparam logic [7:0] NN_STR  = 8'h55;
	localparam logic [7:0] NN_LDR  = 8'h65;

	typedef enum logic [2:0] {
		ALU_ADD = 3'd0,
		ALU_SUB = 3'd1,
		ALU_AND = 3'd2,
		ALU_OR  = 3'd3,
		ALU_XOR = 3'd4
	} alu_op_t;

	typedef struct packed {
		logic [ALU_W-1:0] y;
		logic             nb;
	} alu_res_t;

	localparam logic [7:0] FONT [FONT_BYTES] = '{
		8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
		8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
		8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
	};

endpackage

/* rtl/chip8_instruction_core.sv */
// A sprite draw reduces I, VX and VY modulo their bounds by repeated subtraction, then
// reads and writes the frame once per sprite row drawn. FX33 forms its digits by repeated
// subtraction; FX55/FX65 also reduce I first and then move registers V0 to VX one by one.
// One item at a time; the sequencer around the shared ALU sets the rate.
// After reset a clearing pass over all MEM_BYTES addresses loads font and zeros into memory;
// items are stalled meanwhile, configuration writes are taken.
// ============================================================================
// chip8_instruction_core
// CHIP-8 interpreter core: opcode execute, timers, memory load, display read.
// ============================================================================
`include "chip8_instruction_core_defines.svh"

module chip8_instruction_core import c8core_pkg::*; #(
	parameter int MEM_BYTES     = DEF_MEM_BYTES,
	parameter int STACK_DEPTH   = DEF_STACK_DEPTH,
	parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [1:0]         kind,
	input  logic [15:0]        opcode,
	input  logic [15:0]        key_mask,
	input  logic [7:0]         random_byte,
	input  logic [11:0]        address,
	input  logic [7:0]         data,
	input  logic [4:0]         row,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [11:0]        pc,
	output logic [11:0]        index_value,
	output logic               fault,
	output logic               draw_flag,
	output logic               sound_on,
	output logic               waiting_key,
	output logic [63:0]        display_row
);

	localparam int MA  = $clog2(MEM_BYTES);
	localparam int SPW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int XW  = $clog2(SCREEN_WIDTH);
	localparam int FA  = $clog2(SCREEN_HEIGHT);
	localparam int W   = SCREEN_WIDTH;

	typedef enum logic [21:0] {
		ST_INIT   = 22'h000001,
		ST_IDLE   = 22'h000002,
		ST_RDX    = 22'h000004,
		ST_RDY    = 22'h000008,
		ST_RD0    = 22'h000010,
		ST_EXEC   = 22'h000020,
		ST_IMOD   = 22'h000040,
		ST_MODX   = 22'h000080,
		ST_MODY   = 22'h000100,
		ST_SPR_RD = 22'h000200,
		ST_SPR_WR = 22'h000400,
		ST_BCD    = 22'h000800,
		ST_MEM_WR = 22'h001000,
		ST_ST_RD  = 22'h002000,
		ST_ST_WR  = 22'h004000,
		ST_LD_RD  = 22'h008000,
		ST_LD_WR  = 22'h010000,
		ST_IADV   = 22'h020000,
		ST_WVF    = 22'h040000,
		ST_RET    = 22'h080000,
		ST_ROW    = 22'h100000,
		ST_DONE   = 22'h200000
	} state_t;

	state_t            state_q;
	logic [MA-1:0]     clr_q;
	logic [11:0]       pc_q;
	logic [11:0]       idx_q;
	logic [SPW-1:0]    sp_q;
	logic [7:0]        delay_q;
	logic [7:0]        sound_q;
	logic              original_q;
	logic [15:0]       op_q;
	logic [15:0]       keys_q;
	logic [7:0]        rnd_q;
	logic [4:0]        row_q;
	logic [7:0]        vx_q;
	logic [7:0]        vy_q;
	logic [ALU_W-1:0]  acc_q;
	logic [3:0]        cnt_q;
	logic [MA-1:0]     ptr_q;
	logic [XW-1:0]     x0_q;
	logic [FA-1:0]     y0_q;
	logic              hit_q;
	logic              flag_q;
	logic              ph_q;
	logic [3:0]        dh_q;
	logic [3:0]        dt_q;
	logic              fault_q;
	logic              drew_q;
	logic              wait_q;
	logic [W-1:0]      rowbits_q;
	logic [NUM_REGS-1:0]      reg_vld_q;
	logic [STACK_DEPTH-1:0]   stk_vld_q;
	logic [SCREEN_HEIGHT-1:0] frame_vld_q;
	logic              rvld_q;
	logic              svld_q;
	logic              fvld_q;
	logic              result_valid_q;
	logic [11:0]       out_pc_q;
	logic [11:0]       out_idx_q;
	logic              out_fault_q;
	logic              out_drew_q;
	logic              out_sound_q;
	logic              out_wait_q;
	logic [63:0]       out_row_q;

	logic [3:0]  grp, xi, yi, lo;
	logic [7:0]  nn;
	logic [11:0] nnn, pc2, pc4;
	logic        legal;
	logic [7:0]  regval, reg_rd, t_sh;
	logic [3:0]  key_idx;
	logic        key_found, key_hit;
	logic [SPW-1:0] spinc, spdec;
	logic [MA-1:0]  ptr_inc;
	logic [5:0]     fysum;
	logic           spr_go;
	logic [W+7:0]   spr_wide;
	logic [6:0]     shamt;
	logic [W-1:0]   spr, frame_rd, frame_val;
	logic [11:0]    stk_rd;
	logic [7:0]     mem_rd;
	logic           cfg_wr;

	alu_op_t          alu_op;
	logic [ALU_W-1:0] alu_a, alu_b;
	alu_res_t         alu;

	logic          reg_we;
	logic [3:0]    reg_wa, reg_raddr;
	logic [7:0]    reg_wd;
	logic          mem_we;
	logic [MA-1:0] mem_wa;
	logic [7:0]    mem_wd;
	logic          stk_we;
	logic          frame_we;
	logic [FA-1:0] frame_raddr, frame_wa;

	assign grp = op_q[15:12];
	assign xi  = op_q[11:8];
	assign yi  = op_q[7:4];
	assign lo  = op_q[3:0];
	assign nn  = op_q[7:0];
	assign nnn = op_q[11:0];
	assign pc2 = pc_q + 12'd2;
	assign pc4 = pc_q + 12'd4;

	assign regval    = rvld_q ? reg_rd : 8'd0;
	assign frame_val = fvld_q ? frame_rd : '0;
	assign t_sh      = original_q ? vy_q : vx_q;
	assign key_hit   = keys_q[vx_q[3:0]];
	assign key_found = |keys_q;

	assign spinc   = (sp_q == SPW'(STACK_DEPTH - 1)) ? '0 : sp_q + 1'b1;
	assign spdec   = (sp_q == '0) ? SPW'(STACK_DEPTH - 1) : sp_q - 1'b1;
	assign ptr_inc = (ptr_q == MA'(MEM_BYTES - 1)) ? '0 : ptr_q + 1'b1;

	assign fysum    = 6'(y0_q) + 6'(cnt_q);
	assign spr_go   = (cnt_q < lo) && (fysum < 6'(SCREEN_HEIGHT));
	assign shamt    = 7'(x0_q) + 7'd8;
	assign spr_wide = {mem_rd, {W{1'b0}}} >> shamt;
	assign spr      = spr_wide[W-1:0];

	assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_ORIGINAL);
	assign pready = 1'b1;
	assign prdata = (paddr[PADDR_W-1] == REG_ORIGINAL) ? {31'd0, original_q} : 32'd0;

	assign item_stall = (state_q != ST_IDLE);

	always_comb begin
		key_idx = 4'd0;
		for (int k = 15; k >= 0; k--) begin
			if (keys_q[k]) key_idx = 4'(k);
		end
	end

	always_comb begin
		case (grp)
			GRP_SYS:  legal = (nn == NN_CLS) || (nn == NN_RET);
			GRP_ARI:  legal = lo inside {AR_MOV, AR_OR, AR_AND, AR_XOR, AR_ADD, AR_SUB,
				AR_SHR, AR_SUBN, AR_SHL};
			GRP_KEY:  legal = (nn == NN_SKP) || (nn == NN_SKNP);
			GRP_MISC: legal = nn inside {NN_LDDT, NN_WKEY, NN_SDT, NN_SST, NN_ADDX, NN_FONT,
				NN_BCD, NN_STR, NN_LDR};
			default:  legal = 1'b1;
		endcase
	end

	always_comb begin
		alu_op = ALU_ADD;
		alu_a  = '0;
		alu_b  = '0;
		case (state_q)
			ST_EXEC: begin
				case (grp)
					GRP_SEI, GRP_SNEI: begin
						alu_op = ALU_SUB; alu_a = 13'(vx_q); alu_b = 13'(nn);
					end
					GRP_SER, GRP_SNER: begin
						alu_op = ALU_SUB; alu_a = 13'(vx_q); alu_b = 13'(vy_q);
					end
					GRP_ADDI: begin
						alu_a = 13'(vx_q); alu_b = 13'(nn);
					end
					GRP_ARI: begin
						alu_a = 13'(vx_q);
						alu_b = 13'(vy_q);
						case (lo)
							AR_OR:   alu_op = ALU_OR;
							AR_AND:  alu_op = ALU_AND;
							AR_XOR:  alu_op = ALU_XOR;
							AR_SUB:  alu_op = ALU_SUB;
							AR_SUBN: begin
								alu_op = ALU_SUB; alu_a = 13'(vy_q); alu_b = 13'(vx_q);
							end
							default: alu_op = ALU_ADD;
						endcase
					end
					GRP_JPO: begin
						alu_a = 13'(nnn);
						alu_b = original_q ? 13'(regval) : 13'(vx_q);
					end
					GRP_MISC: begin
						if (nn == NN_FONT) begin
							alu_a = 13'({vx_q[3:0], 2'b00});
							alu_b = 13'(vx_q[3:0]);
						end else begin
							alu_a = 13'(idx_q);
							alu_b = 13'(vx_q);
						end
					end
					default: alu_op = ALU_ADD;
				endcase
			end
			ST_IMOD: begin
				alu_op = ALU_SUB; alu_a = acc_q; alu_b = 13'(MEM_BYTES);
			end
			ST_MODX: begin
				alu_op = ALU_SUB; alu_a = acc_q; alu_b = 13'(SCREEN_WIDTH);
			end
			ST_MODY: begin
				alu_op = ALU_SUB; alu_a = acc_q; alu_b = 13'(SCREEN_HEIGHT);
			end
			ST_BCD: begin
				alu_op = ALU_SUB; alu_a = acc_q; alu_b = ph_q ? 13'd10 : 13'd100;
			end
			ST_IADV: begin
				alu_a = 13'(idx_q); alu_b = 13'(xi) + 13'd1;
			end
			default: alu_op = ALU_ADD;
		endcase
	end

	c8core_alu u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.res (alu)
	);

	always_comb begin
		case (state_q)
			ST_RDX:   reg_raddr = xi;
			ST_RDY:   reg_raddr = yi;
			ST_RD0:   reg_raddr = 4'd0;
			ST_ST_RD: reg_raddr = cnt_q;
			default:  reg_raddr = xi;
		endcase
	end

	always_comb begin
		reg_we = 1'b0;
		reg_wa = xi;
		reg_wd = alu.y[7:0];
		case (state_q)
			ST_EXEC: begin
				if (legal) begin
					case (grp)
						GRP_LDI: begin reg_we = 1'b1; reg_wd = nn; end
						GRP_ADDI: reg_we = 1'b1;
						GRP_RND: begin reg_we = 1'b1; reg_wd = rnd_q & nn; end
						GRP_ARI: begin
							reg_we = 1'b1;
							case (lo)
								AR_MOV:  reg_wd = vy_q;
								AR_SHR:  reg_wd = {1'b0, t_sh[7:1]};
								AR_SHL:  reg_wd = {t_sh[6:0], 1'b0};
								default: reg_wd = alu.y[7:0];
							endcase
						end
						GRP_MISC: begin
							if (nn == NN_LDDT) begin
								reg_we = 1'b1; reg_wd = delay_q;
							end else if (nn == NN_WKEY) begin
								reg_we = key_found; reg_wd = {4'd0, key_idx};
							end
						end
						default: reg_we = 1'b0;
					endcase
				end
			end
			ST_LD_WR: begin reg_we = 1'b1; reg_wa = cnt_q; reg_wd = mem_rd; end
			ST_WVF:   begin reg_we = 1'b1; reg_wa = 4'hF; reg_wd = {7'd0, flag_q}; end
			default:  reg_we = 1'b0;
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = ptr_q;
		mem_wd = regval;
		case (state_q)
			ST_INIT: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = (13'(clr_q) < 13'(FONT_BYTES)) ? FONT[clr_q[6:0]] : 8'd0;
			end
			ST_IDLE: begin
				mem_we = item_valid && (kind_t'(kind) == KIND_LOAD)
					&& (13'(address) < 13'(MEM_BYTES));
				mem_wa = address[MA-1:0];
				mem_wd = data;
			end
			ST_MEM_WR: begin
				mem_we = 1'b1;
				case (cnt_q)
					4'd0:    mem_wd = {4'd0, dh_q};
					4'd1:    mem_wd = {4'd0, dt_q};
					default: mem_wd = {4'd0, acc_q[3:0]};
				endcase
			end
			ST_ST_WR: mem_we = 1'b1;
			default:  mem_we = 1'b0;
		endcase
	end

	assign stk_we      = (state_q == ST_EXEC) && legal && (grp == GRP_CALL);
	assign frame_we    = (state_q == ST_SPR_WR);
	assign frame_wa    = fysum[FA-1:0];
	assign frame_raddr = (state_q == ST_IDLE) ? row[FA-1:0] : fysum[FA-1:0];

	c8core_ram #(.WIDTH(8), .DEPTH(NUM_REGS)) u_regs (
		.clk   (clk),
		.we    (reg_we),
		.waddr (reg_wa),
		.wdata (reg_wd),
		.raddr (reg_raddr),
		.rdata (reg_rd)
	);

	c8core_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_wa),
		.wdata (mem_wd),
		.raddr (ptr_q),
		.rdata (mem_rd)
	);

	c8core_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (sp_q),
		.wdata (pc2),
		.raddr (spdec),
		.rdata (stk_rd)
	);

	c8core_ram #(.WIDTH(SCREEN_WIDTH), .DEPTH(SCREEN_HEIGHT)) u_frame (
		.clk   (clk),
		.we    (frame_we),
		.waddr (frame_wa),
		.wdata (frame_val ^ spr),
		.raddr (frame_raddr),
		.rdata (frame_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_INIT;
			clr_q          <= '0;
			pc_q           <= PC_RESET;
			idx_q          <= '0;
			sp_q           <= '0;
			delay_q        <= '0;
			sound_q        <= '0;
			original_q     <= 1'b0;
			op_q           <= '0;
			keys_q         <= '0;
			rnd_q          <= '0;
			row_q          <= '0;
			vx_q           <= '0;
			vy_q           <= '0;
			acc_q          <= '0;
			cnt_q          <= '0;
			ptr_q          <= '0;
			x0_q           <= '0;
			y0_q           <= '0;
			hit_q          <= 1'b0;
			flag_q         <= 1'b0;
			ph_q           <= 1'b0;
			dh_q           <= '0;
			dt_q           <= '0;
			fault_q        <= 1'b0;
			drew_q         <= 1'b0;
			wait_q         <= 1'b0;
			rowbits_q      <= '0;
			reg_vld_q      <= '0;
			stk_vld_q      <= '0;
			frame_vld_q    <= '0;
			rvld_q         <= 1'b0;
			svld_q         <= 1'b0;
			fvld_q         <= 1'b0;
			result_valid_q <= 1'b0;
			out_pc_q       <= '0;
			out_idx_q      <= '0;
			out_fault_q    <= 1'b0;
			out_drew_q     <= 1'b0;
			out_sound_q    <= 1'b0;
			out_wait_q     <= 1'b0;
			out_row_q      <= '0;
		end else begin
			if (cfg_wr) original_q <= pwdata[0];
			rvld_q <= reg_vld_q[reg_raddr];
			svld_q <= stk_vld_q[spdec];
			fvld_q <= frame_vld_q[frame_raddr];
			if (reg_we) reg_vld_q[reg_wa] <= 1'b1;
			if (stk_we) stk_vld_q[sp_q] <= 1'b1;
			if (frame_we) frame_vld_q[frame_wa] <= 1'b1;
			if (result_valid_q && !result_stall) result_valid_q <= 1'b0;

			case (state_q)
				ST_INIT: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == MA'(MEM_BYTES - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (item_valid) begin
						op_q      <= opcode;
						keys_q    <= key_mask;
						rnd_q     <= random_byte;
						row_q     <= row;
						fault_q   <= 1'b0;
						drew_q    <= 1'b0;
						wait_q    <= 1'b0;
						rowbits_q <= '0;
						case (kind_t'(kind))
							KIND_EXEC: state_q <= ST_RDX;
							KIND_TICK: begin
								if (delay_q != 8'd0) delay_q <= delay_q - 8'd1;
								if (sound_q != 8'd0) sound_q <= sound_q - 8'd1;
								state_q <= ST_DONE;
							end
							KIND_ROW: state_q <= ST_ROW;
							default:  state_q <= ST_DONE;
						endcase
					end
				end
				ST_RDX: state_q <= ST_RDY;
				ST_RDY: begin
					vx_q    <= regval;
					state_q <= ST_RD0;
				end
				ST_RD0: begin
					vy_q    <= regval;
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_DONE;
					if (!legal) begin
						fault_q <= 1'b1;
					end else begin
						pc_q <= pc2;
						case (grp)
							GRP_SYS: begin
								if (nn == NN_CLS) begin
									frame_vld_q <= '0;
									drew_q      <= 1'b1;
								end else begin
									sp_q    <= spdec;
									state_q <= ST_RET;
								end
							end
							GRP_JP: pc_q <= nnn;
							GRP_CALL: begin
								sp_q <= spinc;
								pc_q <= nnn;
							end
							GRP_SEI, GRP_SER: if (alu.y == '0) pc_q <= pc4;
							GRP_SNEI, GRP_SNER: if (alu.y != '0) pc_q <= pc4;
							GRP_ARI: begin
								case (lo)
									AR_ADD: begin flag_q <= alu.y[8]; state_q <= ST_WVF; end
									AR_SUB, AR_SUBN: begin
										flag_q  <= alu.nb;
										state_q <= ST_WVF;
									end
									AR_SHR: begin flag_q <= t_sh[0]; state_q <= ST_WVF; end
									AR_SHL: begin flag_q <= t_sh[7]; state_q <= ST_WVF; end
									default: flag_q <= flag_q;
								endcase
							end
							GRP_LDIX: idx_q <= nnn;
							GRP_JPO:  pc_q <= alu.y[11:0];
							GRP_DRW: begin
								drew_q  <= 1'b1;
								hit_q   <= 1'b0;
								cnt_q   <= '0;
								acc_q   <= 13'(idx_q);
								state_q <= ST_IMOD;
							end
							GRP_KEY: begin
								if ((nn == NN_SKP) == key_hit) pc_q <= pc4;
							end
							GRP_MISC: begin
								case (nn)
									NN_WKEY: begin
										if (!key_found) begin
											pc_q   <= pc_q;
											wait_q <= 1'b1;
										end
									end
									NN_SDT:  delay_q <= vx_q;
									NN_SST:  sound_q <= vx_q;
									NN_ADDX, NN_FONT: idx_q <= alu.y[11:0];
									NN_BCD, NN_STR, NN_LDR: begin
										acc_q   <= 13'(idx_q);
										cnt_q   <= '0;
										ph_q    <= 1'b0;
										dh_q    <= '0;
										dt_q    <= '0;
										state_q <= ST_IMOD;
									end
									default: wait_q <= 1'b0;
								endcase
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_IMOD: begin
					if (alu.nb) begin
						acc_q <= alu.y;
					end else begin
						ptr_q <= acc_q[MA-1:0];
						if (grp == GRP_DRW) begin
							acc_q   <= 13'(vx_q);
							state_q <= ST_MODX;
						end else if (nn == NN_BCD) begin
							acc_q   <= 13'(vx_q);
							state_q <= ST_BCD;
						end else if (nn == NN_STR) begin
							state_q <= ST_ST_RD;
						end else begin
							state_q <= ST_LD_RD;
						end
					end
				end
				ST_MODX: begin
					if (alu.nb) begin
						acc_q <= alu.y;
					end else begin
						x0_q    <= acc_q[XW-1:0];
						acc_q   <= 13'(vy_q);
						state_q <= ST_MODY;
					end
				end
				ST_MODY: begin
					if (alu.nb) begin
						acc_q <= alu.y;
					end else begin
						y0_q    <= acc_q[FA-1:0];
						state_q <= ST_SPR_RD;
					end
				end
				ST_SPR_RD: begin
					if (spr_go) begin
						state_q <= ST_SPR_WR;
					end else begin
						flag_q  <= hit_q;
						state_q <= ST_WVF;
					end
				end
				ST_SPR_WR: begin
					if (|(frame_val & spr)) hit_q <= 1'b1;
					cnt_q   <= cnt_q + 4'd1;
					ptr_q   <= ptr_inc;
					state_q <= ST_SPR_RD;
				end
				ST_BCD: begin
					if (alu.nb) begin
						acc_q <= alu.y;
						if (ph_q) dt_q <= dt_q + 4'd1;
						else dh_q <= dh_q + 4'd1;
					end else if (!ph_q) begin
						ph_q <= 1'b1;
					end else begin
						cnt_q   <= '0;
						state_q <= ST_MEM_WR;
					end
				end
				ST_MEM_WR: begin
					ptr_q <= ptr_inc;
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd2) state_q <= ST_DONE;
				end
				ST_ST_RD: state_q <= ST_ST_WR;
				ST_ST_WR: begin
					ptr_q <= ptr_inc;
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == xi) state_q <= original_q ? ST_IADV : ST_DONE;
					else state_q <= ST_ST_RD;
				end
				ST_LD_RD: state_q <= ST_LD_WR;
				ST_LD_WR: begin
					ptr_q <= ptr_inc;
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == xi) state_q <= original_q ? ST_IADV : ST_DONE;
					else state_q <= ST_LD_RD;
				end
				ST_IADV: begin
					idx_q   <= alu.y[11:0];
					state_q <= ST_DONE;
				end
				ST_WVF: state_q <= ST_DONE;
				ST_RET: begin
					pc_q    <= svld_q ? stk_rd : 12'd0;
					state_q <= ST_DONE;
				end
				ST_ROW: begin
					if (6'(row_q) < 6'(SCREEN_HEIGHT)) rowbits_q <= frame_val;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!result_valid_q || !result_stall) begin
						result_valid_q <= 1'b1;
						out_pc_q       <= pc_q;
						out_idx_q      <= idx_q;
						out_fault_q    <= fault_q;
						out_drew_q     <= drew_q;
						out_sound_q    <= (sound_q != 8'd0);
						out_wait_q     <= wait_q;
						out_row_q      <= 64'(rowbits_q) << (64 - W);
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign pc           = out_pc_q;
	assign index_value  = out_idx_q;
	assign fault        = out_fault_q;
	assign draw_flag    = out_drew_q;
	assign sound_on     = out_sound_q;
	assign waiting_key  = out_wait_q;
	assign display_row  = out_row_q;

	`C8_ASSERT_NEXT(a_accept_leaves_idle, item_valid && !item_stall, state_q != ST_IDLE)
	`C8_ASSERT_IMPL(a_result_from_done, $rose(result_valid_q), $past(state_q) == ST_DONE)
	`C8_ASSERT_NEXT(a_fault_keeps_pc, state_q == ST_EXEC && !legal, pc_q == $past(pc_q) && fault_q)

endmodule

/* rtl/c8core_ram.sv */
// ============================================================================
// c8core_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module c8core_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/c8core_alu.sv */
// ============================================================================
// c8core_alu
// Shared add, subtract/compare and logic unit of the core.
// ============================================================================
module c8core_alu import c8core_pkg::*; (
	input  alu_op_t          op,
	input  logic [ALU_W-1:0] a,
	input  logic [ALU_W-1:0] b,
	output alu_res_t         res
);

	logic [ALU_W:0] diff;

	always_comb begin
		diff   = {1'b0, a} - {1'b0, b};
		res.nb = ~diff[ALU_W];
		case (op)
			ALU_ADD: res.y = a + b;
			ALU_SUB: res.y = diff[ALU_W-1:0];
			ALU_AND: res.y = a & b;
			ALU_OR:  res.y = a | b;
			ALU_XOR: res.y = a ^ b;
			default: res.y = a + b;
		endcase
	end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CHIP-8 core testbench
// Drives opcode, tick, load and row-read items through the valid/stall ports.
// Results are checked field by field against an in-bench model or set values.
// The mode register is changed between phases over the APB port.
// ----------------------------------------------------------------------------
module testbench;
	import c8core_pkg::*;

	localparam logic [PADDR_W-1:0] ADDR_ORIGINAL = PADDR_W'(0);

	typedef struct {
		logic [1:0]  kind;
		logic [15:0] opcode;
		logic [15:0] key_mask;
		logic [7:0]  random_byte;
		logic [11:0] address;
		logic [7:0]  data;
		logic [4:0]  row;
	} item_t;

	typedef struct {
		logic [11:0] pc;
		logic [11:0] index_value;
		logic        fault;
		logic        draw_flag;
		logic        sound_on;
		logic        waiting_key;
		logic [63:0] display_row;
	} outcome_t;

	typedef struct {
		item_t    it;
		bit       typed;
		outcome_t res;
	} row_t;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic item_valid, item_stall;
	logic [1:0] kind;
	logic [15:0] opcode, key_mask;
	logic [7:0] random_byte, data;
	logic [11:0] address;
	logic [4:0] row;
	logic result_valid, result_stall;
	logic [11:0] pc, index_value;
	logic fault, draw_flag, sound_on, waiting_key;
	logic [63:0] display_row;

	chip8_instruction_core dut (.*);

	logic [7:0]  ram [4096];
	logic [7:0]  vreg [16];
	logic [11:0] calls [16];
	logic [3:0]  sp;
	logic [11:0] pc_m, i_m;
	logic [7:0]  delay_m, sound_m;
	logic [63:0] frame [32];
	logic        orig_mode;

	outcome_t expected_q [$];
	int errors = 0;
	int send_idle = 0, recv_stall = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("testbench failed");
		$finish;
	end

	function automatic logic [11:0] inc2(logic [11:0] v);
		return v + 12'd2;
	endfunction

	function automatic outcome_t core_step(item_t it);
		outcome_t o;
		logic [3:0] x, y;
		logic [7:0] nn, vx, vy, t, ln;
		logic [11:0] nnn, saved;
		logic [8:0] s;
		int i, r, c, px, py;
		logic hit;
		o = '{default: '0};
		if (it.kind == KIND_EXEC) begin
			x = it.opcode[11:8]; y = it.opcode[7:4];
			nn = it.opcode[7:0]; nnn = it.opcode[11:0];
			vx = vreg[x]; vy = vreg[y];
			saved = pc_m;
			pc_m = inc2(pc_m);
			case (it.opcode[15:12])
				GRP_SYS: begin
					if (nn == NN_CLS) begin
						foreach (frame[k]) frame[k] = '0;
						o.draw_flag = 1;
					end else if (nn == NN_RET) begin
						sp = sp - 4'd1;
						pc_m = calls[sp];
					end else o.fault = 1;
				end
				GRP_JP: pc_m = nnn;
				GRP_CALL: begin
					calls[sp] = pc_m;
					sp = sp + 4'd1;
					pc_m = nnn;
				end
				GRP_SEI: if (vx == nn) pc_m = inc2(pc_m);
				GRP_SNEI: if (vx != nn) pc_m = inc2(pc_m);
				GRP_SER: if (vx == vy) pc_m = inc2(pc_m);
				GRP_LDI: vreg[x] = nn;
				GRP_ADDI: vreg[x] = vx + nn;
				GRP_ARI: case (it.opcode[3:0])
					AR_MOV: vreg[x] = vy;
					AR_OR: vreg[x] = vx | vy;
					AR_AND: vreg[x] = vx & vy;
					AR_XOR: vreg[x] = vx ^ vy;
					AR_ADD: begin
						s = vx + vy;
						vreg[x] = s[7:0]; vreg[15] = {7'd0, s[8]};
					end
					AR_SUB: begin
						vreg[x] = vx - vy; vreg[15] = {7'd0, vx >= vy};
					end
					AR_SHR: begin
						t = orig_mode ? vy : vx;
						vreg[x] = t >> 1; vreg[15] = {7'd0, t[0]};
					end
					AR_SUBN: begin
						vreg[x] = vy - vx; vreg[15] = {7'd0, vy >= vx};
					end
					AR_SHL: begin
						t = orig_mode ? vy : vx;
						vreg[x] = t << 1; vreg[15] = {7'd0, t[7]};
					end
					default: o.fault = 1;
				endcase
				GRP_SNER: if (vx != vy) pc_m = inc2(pc_m);
				GRP_LDIX: i_m = nnn;
				GRP_JPO: pc_m = nnn + {4'd0, orig_mode ? vreg[0] : vx};
				GRP_RND: vreg[x] = it.random_byte & nn;
				GRP_DRW: begin
					hit = 0;
					for (r = 0; r < it.opcode[3:0]; r++) begin
						py = vy % 32 + r;
						if (py >= 32) break;
						ln = ram[12'(i_m + r)];
						for (c = 0; c < 8; c++) begin
							px = vx % 64 + c;
							if (px >= 64) break;
							if (ln[7-c]) begin
								if (frame[py][63-px]) hit = 1;
								frame[py][63-px] = ~frame[py][63-px];
							end
						end
					end
					vreg[15] = {7'd0, hit};
					o.draw_flag = 1;
				end
				GRP_KEY: begin
					if (nn == NN_SKP) begin
						if (it.key_mask[vx[3:0]]) pc_m = inc2(pc_m);
					end else if (nn == NN_SKNP) begin
						if (!it.key_mask[vx[3:0]]) pc_m = inc2(pc_m);
					end else o.fault = 1;
				end
				default: case (nn)
					NN_LDDT: vreg[x] = delay_m;
					NN_WKEY: begin
						for (i = 0; i < 16; i++) if (it.key_mask[i]) break;
						if (i < 16) vreg[x] = 8'(i);
						else begin
							pc_m = pc_m - 12'd2;
							o.waiting_key = 1;
						end
					end
					NN_SDT: delay_m = vx;
					NN_SST: sound_m = vx;
					NN_ADDX: i_m = i_m + {4'd0, vx};
					NN_FONT: i_m = 12'(5 * vx[3:0]);
					NN_BCD: begin
						ram[i_m] = vx / 100;
						ram[12'(i_m + 1)] = (vx / 10) % 10;
						ram[12'(i_m + 2)] = vx % 10;
					end
					NN_STR: begin
						for (i = 0; i <= x; i++) ram[12'(i_m + i)] = vreg[i];
						if (orig_mode) i_m = i_m + x + 12'd1;
					end
					NN_LDR: begin
						for (i = 0; i <= x; i++) vreg[i] = ram[12'(i_m + i)];
						if (orig_mode) i_m = i_m + x + 12'd1;
					end
					default: o.fault = 1;
				endcase
			endcase
			if (o.fault) pc_m = saved;
		end else if (it.kind == KIND_TICK) begin
			if (delay_m != 0) delay_m--;
			if (sound_m != 0) sound_m--;
		end else if (it.kind == KIND_LOAD) begin
			ram[it.address] = it.data;
		end else begin
			o.display_row = frame[it.row];
		end
		o.pc = pc_m;
		o.index_value = i_m;
		o.sound_on = sound_m != 0;
		return o;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		outcome_t e;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_q.size() == 0) report("unexpected item", 0, 0);
				else begin
					e = expected_q.pop_front();
					if (pc !== e.pc) report("pc", pc, e.pc);
					if (index_value !== e.index_value)
						report("index_value", index_value, e.index_value);
					if (fault !== e.fault) report("fault", fault, e.fault);
					if (draw_flag !== e.draw_flag) report("draw_flag", draw_flag, e.draw_flag);
					if (sound_on !== e.sound_on) report("sound_on", sound_on, e.sound_on);
					if (waiting_key !== e.waiting_key)
						report("waiting_key", waiting_key, e.waiting_key);
					if (display_row !== e.display_row)
						report("display_row", display_row, e.display_row);
				end
			end
			result_stall <= ($urandom_range(99) < recv_stall);
		end
	end

	task automatic write_mode(logic v);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_ORIGINAL; pwdata <= {31'd0, v};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		orig_mode = v;
	endtask

	task automatic send(item_t it, bit typed, outcome_t want);
		outcome_t e;
		while (($urandom_range(99) < send_idle)) begin
			item_valid <= 0;
			@(posedge clk);
		end
		kind <= it.kind; opcode <= it.opcode; key_mask <= it.key_mask;
		random_byte <= it.random_byte; address <= it.address; data <= it.data;
		row <= it.row; item_valid <= 1;
		e = core_step(it);
		if (typed) expected_q.push_back(want);
		else expected_q.push_back(e);
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	task automatic drain();
		int n = 0;
		item_valid <= 0;
		while (expected_q.size() != 0 && n < 200000) begin
			@(posedge clk); n++;
		end
		if (expected_q.size() != 0) begin
			$display("testbench failed");
			$finish;
		end
		repeat (60) @(posedge clk);
	endtask

	function automatic item_t rand_item();
		item_t it;
		int p;
		it.key_mask = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom);
		it.random_byte = 8'($urandom);
		it.address = 12'($urandom);
		it.data = 8'($urandom);
		it.row = 5'($urandom);
		it.opcode = 16'($urandom);
		p = $urandom_range(99);
		if (p < 70) it.kind = KIND_EXEC;
		else if (p < 78) it.kind = KIND_TICK;
		else if (p < 90) it.kind = KIND_LOAD;
		else it.kind = KIND_ROW;
		if (it.kind == KIND_LOAD && $urandom_range(1)) it.address = 12'h200 | it.address[8:0];
		if (it.kind == KIND_EXEC) begin
			p = $urandom_range(99);
			if (p < 15) it.opcode = {GRP_DRW, it.opcode[11:0]};
			else if (p < 30) it.opcode = {GRP_ARI, it.opcode[11:4],
				4'($urandom_range(1) ? $urandom_range(7) : 14)};
			else if (p < 45) begin
				case ($urandom_range(12))
					0: it.opcode[7:0] = NN_LDDT;  1: it.opcode[7:0] = NN_WKEY;
					2: it.opcode[7:0] = NN_SDT;   3: it.opcode[7:0] = NN_SST;
					4: it.opcode[7:0] = NN_ADDX;  5: it.opcode[7:0] = NN_FONT;
					6: it.opcode[7:0] = NN_BCD;   7: it.opcode[7:0] = NN_STR;
					8: it.opcode[7:0] = NN_LDR;   default: ;
				endcase
				it.opcode[15:12] = GRP_MISC;
			end else if (p < 52) it.opcode = {GRP_KEY, it.opcode[11:8],
				$urandom_range(1) ? NN_SKP : NN_SKNP};
			else if (p < 58) it.opcode = {GRP_SYS, it.opcode[11:8],
				$urandom_range(1) ? NN_CLS : NN_RET};
		end
		return it;
	endfunction

	row_t dir [] ;
	item_t zi;
	outcome_t zo;

	initial begin
		int n;
		zi = '{default: '0};
		zo = '{default: '0};
		arst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		item_valid = 0; kind = KIND_EXEC; opcode = 0; key_mask = 0; random_byte = 0;
		address = 0; data = 0; row = 0; result_stall = 0;
		foreach (ram[k]) ram[k] = (k < FONT_BYTES) ? FONT[k] : 8'd0;
		foreach (vreg[k]) vreg[k] = 0;
		foreach (calls[k]) calls[k] = 0;
		foreach (frame[k]) frame[k] = 0;
		sp = 0; pc_m = PC_RESET; i_m = 0; delay_m = 0; sound_m = 0; orig_mode = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		write_mode(0);

		dir = new[22];
		foreach (dir[k]) dir[k] = '{zi, 0, zo};
		dir[0].it.kind = KIND_ROW; dir[0].it.row = 5'd31;
		dir[0].typed = 1; dir[0].res.pc = PC_RESET;
		dir[1].it.opcode = 16'h0000; dir[1].typed = 1;
		dir[1].res.pc = PC_RESET; dir[1].res.fault = 1;
		dir[2].it.opcode = 16'hFFFF; dir[2].typed = 1;
		dir[2].res.pc = PC_RESET; dir[2].res.fault = 1;
		dir[3].it.opcode = 16'h6FFF;
		dir[4].it.opcode = 16'h8FF4;
		dir[5].it.opcode = 16'h8005;
		dir[6].it.opcode = 16'h8FF7;
		dir[7].it.opcode = 16'hF00A; dir[7].it.key_mask = 16'h8000;
		dir[8].it.opcode = 16'hF10A;
		dir[9].it.opcode = 16'hA000;
		dir[10].it.opcode = 16'hD00F;
		dir[11].it.opcode = 16'h603F;
		dir[12].it.opcode = 16'h611F;
		dir[13].it.opcode = 16'hD01F;
		dir[14].it.kind = KIND_ROW; dir[14].it.row = 5'd31;
		dir[15].it.opcode = 16'hD010;
		dir[16].it.opcode = 16'h2FFF;
		dir[17].it.opcode = 16'h00EE;
		dir[18].it.opcode = 16'hFF33;
		dir[19].it.opcode = 16'hFF65;
		dir[20].it.kind = KIND_LOAD; dir[20].it.address = 12'hFFF; dir[20].it.data = 8'hFF;
		dir[21].it.opcode = 16'hBFFF;
		foreach (dir[k]) send(dir[k].it, dir[k].typed, dir[k].res);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			write_mode(ph[0]);
			case (ph % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 76; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 76; end
				default: begin send_idle = 20; recv_stall = 20; end
			endcase
			n = 0;
			while (n < 160) begin
				send(rand_item(), 0, zo);
				n++;
			end
			drain();
		end
		if (errors == 0) $display("testbench passed");
		else $display("testbench failed");
		$finish;
	end
endmodule
